FILE: src/green_ampt_infiltration_cell_assert.svh
// Assertion macros used by the checker of the Green-Ampt cell.
`ifndef GREEN_AMPT_INFILTRATION_CELL_ASSERT_SVH
`define GREEN_AMPT_INFILTRATION_CELL_ASSERT_SVH

`define GAIC_AP_IMP(lbl, ck, rs, pre, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (con)) \
    else $error("gaic check failed");

`define GAIC_AP_NXT(lbl, ck, rs, pre, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (con)) \
    else $error("gaic check failed");

`endif

FILE: src/gaic_pkg.sv
`timescale 1ns / 1ps
package gaic_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int MUL_W      = 64;
  localparam int MUL_DIGIT  = 16;
  localparam int MUL_STEPS  = MUL_W / MUL_DIGIT;
  localparam int MUL_CW     = $clog2(MUL_STEPS);

  localparam int ROOT_W     = 53;
  localparam int ROOT_CW    = $clog2(ROOT_W);

  localparam int DIV_W      = 32;
  localparam int DIV_CW     = $clog2(DIV_W);

  localparam logic [31:0] M32 = 32'hFFFF_FFFF;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [31:0] TIME_STEP_RST  = 32'd65536;
  localparam logic [23:0] CELL_WIDTH_RST = 24'd25600;

  typedef enum logic [1:0] {
    REG_TIME_STEP  = 2'd0,
    REG_CELL_WIDTH = 2'd1,
    REG_SMA_MODE   = 2'd2
  } gaic_reg_t;

  typedef enum logic {
    KIND_SKIP = 1'b0,
    KIND_CALC = 1'b1
  } gaic_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_PREP2, ST_SQ_GO, ST_SQ, ST_AX_GO, ST_AX,
    ST_ROOT_GO, ST_ROOT, ST_DEL, ST_FIN_GO, ST_FIN, ST_OUT
  } gaic_state_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic [23:0] cell_width;
    logic        sma_mode;
  } gaic_cfg_t;

  typedef struct packed {
    logic        first_cell;
    logic        in_domain;
    logic        is_channel;
    logic [31:0] ponded_depth;
    logic [31:0] cum_depth;
    logic [47:0] cum_volume;
    logic [31:0] conductivity;
    logic [31:0] suction_head;
    logic [15:0] moisture_deficit;
    logic [23:0] channel_width;
    logic [23:0] channel_length;
    logic [31:0] rain_rate;
  } gaic_item_t;

  typedef struct packed {
    gaic_kind_t kind;
    gaic_item_t item;
  } gaic_entry_t;

endpackage

FILE: src/gaic_front.sv
`timescale 1ns / 1ps
module gaic_front import gaic_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [271:0]  s_axis_tdata,
  input  logic [2:0]    s_axis_tuser,
  input  logic          pop,
  output gaic_entry_t   head,
  output logic          empty
);

  gaic_entry_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;
  gaic_entry_t             in_entry;
  logic                    push;
  logic                    take;

  always_comb begin
    in_entry.item.first_cell       = s_axis_tuser[0];
    in_entry.item.in_domain        = s_axis_tuser[1];
    in_entry.item.is_channel       = s_axis_tuser[2];
    in_entry.item.ponded_depth     = s_axis_tdata[31:0];
    in_entry.item.cum_depth        = s_axis_tdata[63:32];
    in_entry.item.cum_volume       = s_axis_tdata[111:64];
    in_entry.item.conductivity     = s_axis_tdata[143:112];
    in_entry.item.suction_head     = s_axis_tdata[175:144];
    in_entry.item.moisture_deficit = s_axis_tdata[191:176];
    in_entry.item.channel_width    = s_axis_tdata[215:192];
    in_entry.item.channel_length   = s_axis_tdata[239:216];
    in_entry.item.rain_rate        = s_axis_tdata[271:240];
    in_entry.kind = s_axis_tuser[1] ? KIND_CALC : KIND_SKIP;
  end

  assign s_axis_tready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty         = (count == '0);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign take          = pop && !empty;
  assign head          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/gaic_mul.sv
`timescale 1ns / 1ps
module gaic_mul import gaic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_W-1:0]   op_a,
  input  logic [MUL_W-1:0]   op_b,
  output logic               busy,
  output logic [2*MUL_W-1:0] prod
);

  logic [MUL_W-1:0]           a;
  logic [MUL_W-1:0]           b;
  logic [MUL_CW-1:0]          cnt;
  logic [MUL_W+MUL_DIGIT-1:0] part;

  assign part = (MUL_W+MUL_DIGIT)'(a) * (MUL_W+MUL_DIGIT)'(b[MUL_W-1 -: MUL_DIGIT]);

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= op_a;
      b    <= op_b;
      prod <= '0;
      cnt  <= '0;
    end else if (busy) begin
      prod <= {prod[2*MUL_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}}
              + (2*MUL_W)'(part);
      b    <= {b[MUL_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == MUL_CW'(MUL_STEPS-1)) begin
      busy <= 1'b0;
    end
  end

endmodule

FILE: src/gaic_root.sv
`timescale 1ns / 1ps
module gaic_root import gaic_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                busy,
  output logic [ROOT_W-1:0]   root
);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+2:0]   rem;
  logic [ROOT_W+4:0]   rem_sh;
  logic [ROOT_W+4:0]   trial;
  logic                fits;
  logic [ROOT_CW-1:0]  cnt;

  assign rem_sh = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial  = (ROOT_W+5)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[2*ROOT_W-3:0], 2'b00};
      rem  <= fits ? (ROOT_W+3)'(rem_sh - trial) : (ROOT_W+3)'(rem_sh);
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == ROOT_CW'(ROOT_W-1)) begin
      busy <= 1'b0;
    end
  end

endmodule

FILE: src/gaic_div.sv
`timescale 1ns / 1ps
module gaic_div import gaic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2*DIV_W-1:0] num,
  input  logic [DIV_W-1:0]   den,
  output logic               busy,
  output logic [DIV_W-1:0]   quo
);

  logic [DIV_W-1:0]  d;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  lo;
  logic [DIV_W:0]    r2;
  logic              ge;
  logic [DIV_CW-1:0] cnt;
  logic              zero_den;
  logic              ovf;

  assign zero_den = (den == '0);
  assign ovf      = num[2*DIV_W-1:DIV_W] >= den;
  assign r2       = {rem, lo[DIV_W-1]};
  assign ge       = r2 >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (start) begin
      d   <= den;
      rem <= num[2*DIV_W-1:DIV_W];
      lo  <= num[DIV_W-1:0];
      cnt <= '0;
      if (zero_den) begin
        quo <= '0;
      end else if (ovf) begin
        quo <= M32;
      end else begin
        quo <= '0;
      end
    end else if (busy) begin
      rem <= ge ? DIV_W'(r2 - {1'b0, d}) : DIV_W'(r2);
      lo  <= {lo[DIV_W-2:0], 1'b0};
      quo <= {quo[DIV_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !zero_den && !ovf;
    end else if (busy && cnt == DIV_CW'(DIV_W-1)) begin
      busy <= 1'b0;
    end
  end

endmodule

FILE: src/gaic_back.sv
`timescale 1ns / 1ps
module gaic_back import gaic_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  gaic_cfg_t     cfg,
  input  gaic_entry_t   head,
  input  logic          empty,
  output logic          pop,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [239:0]  m_axis_tdata,
  output logic          m_axis_tuser
);

  gaic_state_t state, state_next;
  gaic_entry_t ent;

  logic [63:0]  k_dt;
  logic [47:0]  sd;
  logic [63:0]  rain_dt;
  logic [47:0]  w2;
  logic [47:0]  ach;
  logic [47:0]  a_val;
  logic [48:0]  mag;
  logic         neg;
  logic [51:0]  m2;
  logic [47:0]  area;
  logic [127:0] sq;
  logic [105:0] x;
  logic [47:0]  del;

  logic [47:0]  a_c;
  logic [48:0]  two_f_c;
  logic         neg_c;
  logic [47:0]  ach_c;
  logic [53:0]  sum_c;
  logic [52:0]  half_c;
  logic [47:0]  hi_c;

  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_busy;
  logic [127:0] mul_prod;
  logic         root_start;
  logic         root_busy;
  logic [52:0]  root_val;
  logic         div_start;
  logic         div_busy;
  logic [31:0]  quo;
  logic         load;

  logic         calc;
  logic [31:0]  inc_c;
  logic [32:0]  dsum_c;
  logic [31:0]  depth_c;
  logic [56:0]  vsum_c;
  logic [47:0]  vol_c;
  logic [31:0]  base_min;
  logic [31:0]  base_max;
  logic [31:0]  min_c;
  logic [31:0]  max_c;
  logic [31:0]  sweep_min;
  logic [31:0]  sweep_max;

  gaic_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .busy(mul_busy), .prod(mul_prod)
  );

  gaic_root u_root (
    .clk(clk), .rst(rst), .start(root_start), .radicand(x),
    .busy(root_busy), .root(root_val)
  );

  gaic_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num({del, 16'h0000}),
    .den(cfg.time_step), .busy(div_busy), .quo(quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (!empty) begin
                    state_next = (head.kind == KIND_CALC) ? ST_PREP : ST_OUT;
                  end
      ST_PREP:    state_next = ST_PREP2;
      ST_PREP2:   state_next = ST_SQ_GO;
      ST_SQ_GO:   state_next = ST_SQ;
      ST_SQ:      if (!mul_busy) state_next = ST_AX_GO;
      ST_AX_GO:   state_next = ST_AX;
      ST_AX:      if (!mul_busy) state_next = ST_ROOT_GO;
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT:    if (!root_busy) state_next = ST_DEL;
      ST_DEL:     state_next = ST_FIN_GO;
      ST_FIN_GO:  state_next = ST_FIN;
      ST_FIN:     if (!mul_busy && !div_busy) state_next = ST_OUT;
      ST_OUT:     if (load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == ST_IDLE) && !empty;
    mul_start  = 1'b0;
    mul_a      = {15'h0, mag};
    mul_b      = {15'h0, mag};
    root_start = (state == ST_ROOT_GO);
    div_start  = (state == ST_FIN_GO);
    load       = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
    case (state)
      ST_SQ_GO: begin
        mul_start = 1'b1;
      end
      ST_AX_GO: begin
        mul_start = 1'b1;
        mul_a     = {16'h0, a_val};
        mul_b     = {12'h0, m2};
      end
      ST_FIN_GO: begin
        mul_start = 1'b1;
        mul_a     = {16'h0, del};
        mul_b     = {16'h0, area};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    a_c     = k_dt[63:16];
    two_f_c = {ent.item.cum_depth, 17'h0};
    neg_c   = {1'b0, a_c} < two_f_c;
    ach_c   = ent.item.is_channel ? ach : 48'h0;
    sum_c   = neg ? ((root_val >= mag[48:0]) ? 54'(root_val) - 54'(mag) : 54'h0)
                  : 54'(root_val) + 54'(mag);
    half_c  = sum_c[53:1];
    hi_c    = {ent.item.ponded_depth, 16'h0};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= head;
    end
    if (state == ST_PREP) begin
      k_dt    <= 64'(ent.item.conductivity) * 64'(cfg.time_step);
      sd      <= 48'(ent.item.suction_head) * 48'(ent.item.moisture_deficit);
      rain_dt <= 64'(ent.item.rain_rate) * 64'(cfg.time_step);
      w2      <= 48'(cfg.cell_width) * 48'(cfg.cell_width);
      ach     <= 48'(ent.item.channel_width) * 48'(ent.item.channel_length);
    end
    if (state == ST_PREP2) begin
      a_val <= a_c;
      neg   <= neg_c;
      mag   <= neg_c ? two_f_c - {1'b0, a_c} : {1'b0, a_c} - two_f_c;
      m2    <= {(49'({ent.item.cum_depth, 16'h0}) + 49'(sd)), 3'b000};
      area  <= (w2 > ach_c) ? w2 - ach_c : 48'h0;
    end
    if (state == ST_SQ && !mul_busy) begin
      sq <= mul_prod;
    end
    if (state == ST_AX && !mul_busy) begin
      x <= 106'(sq + mul_prod);
    end
    if (state == ST_DEL) begin
      del <= ({1'b0, half_c} > {6'h0, hi_c}) ? hi_c : half_c[47:0];
    end
  end

  always_comb begin
    calc     = (ent.kind == KIND_CALC);
    inc_c    = del[47:16];
    dsum_c   = {1'b0, ent.item.cum_depth} + {1'b0, inc_c};
    depth_c  = dsum_c[32] ? M32 : dsum_c[31:0];
    vsum_c   = {9'h0, ent.item.cum_volume} + {1'b0, mul_prod[95:40]};
    vol_c    = (vsum_c > {9'h0, M48}) ? M48 : vsum_c[47:0];
    base_min = ent.item.first_cell ? 32'h0 : sweep_min;
    base_max = ent.item.first_cell ? 32'h0 : sweep_max;
    min_c    = (calc && depth_c < base_min) ? depth_c : base_min;
    max_c    = (calc && depth_c > base_max) ? depth_c : base_max;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tuser         <= calc;
      m_axis_tdata[31:0]   <= calc ? quo : 32'h0;
      m_axis_tdata[63:32]  <= calc ? depth_c : 32'h0;
      m_axis_tdata[111:64] <= calc ? vol_c : 48'h0;
      m_axis_tdata[143:112] <= (calc && cfg.sma_mode) ? inc_c : 32'h0;
      m_axis_tdata[175:144] <= (calc && cfg.sma_mode) ? rain_dt[63:32] : 32'h0;
      m_axis_tdata[207:176] <= min_c;
      m_axis_tdata[239:208] <= max_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      sweep_min     <= '0;
      sweep_max     <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        m_axis_tvalid <= 1'b1;
        sweep_min     <= min_c;
        sweep_max     <= max_c;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/green_ampt_infiltration_cell.sv
`timescale 1ns / 1ps
// Channel   | Direction | Content
// s_axis    | in        | one grid cell per beat
// m_axis    | out       | one result per cell
// cfg       | in        | register writes, always ready
//
// A cell in the domain passes through the engine from leaving the queue to the
// output register, its time set mostly by the 53-step square root and the
// 32-step rate division on units of their own; the multiplier is shared. When
// the rate saturates or the time step is zero, the division is skipped. A
// cell outside the domain goes from the queue straight to the output register.
// Reset clears the queue and the sweep minimum and maximum, and loads the
// register defaults.
// A four-entry queue accepts cells while the engine works and while a
// result waits in the output register.
module green_ampt_infiltration_cell import gaic_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // ponded_depth, cum_depth, cum_volume, conductivity, suction_head,
  // moisture_deficit, channel_width, channel_length, rain_rate
  input  logic [271:0]  s_axis_tdata,
  // first_cell, in_domain, is_channel
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // infil_rate, new_depth, new_volume, step_infil_depth, step_rain_depth,
  // min_depth, max_depth
  output logic [239:0]  m_axis_tdata,
  // valid_cell
  output logic          m_axis_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  gaic_cfg_t   cfg;
  gaic_entry_t head;
  logic        empty;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step  <= TIME_STEP_RST;
      cfg.cell_width <= CELL_WIDTH_RST;
      cfg.sma_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (gaic_reg_t'(cfg_index))
        REG_TIME_STEP:  cfg.time_step  <= cfg_data;
        REG_CELL_WIDTH: cfg.cell_width <= cfg_data[23:0];
        REG_SMA_MODE:   cfg.sma_mode   <= cfg_data[0];
        default:        cfg            <= cfg;
      endcase
    end
  end

  gaic_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .pop(pop), .head(head), .empty(empty)
  );

  gaic_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .empty(empty), .pop(pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

FILE: src/gaic_checker.sv
`timescale 1ns / 1ps
`include "green_ampt_infiltration_cell_assert.svh"
module gaic_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [239:0]  m_axis_tdata,
  input logic          m_axis_tuser
);

  `GAIC_AP_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `GAIC_AP_IMP(a_outside_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[175:0] == 176'h0)
  `GAIC_AP_IMP(a_min_le_max, clk, rst, m_axis_tvalid, m_axis_tdata[207:176] <= m_axis_tdata[239:208])
  `GAIC_AP_IMP(a_depth_ge_step, clk, rst, m_axis_tvalid, m_axis_tdata[63:32] >= m_axis_tdata[143:112])

endmodule

bind green_ampt_infiltration_cell gaic_checker u_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import gaic_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        valid_cell;
    logic [31:0] infil_rate;
    logic [31:0] new_depth;
    logic [47:0] new_volume;
    logic [31:0] step_infil_depth;
    logic [31:0] step_rain_depth;
    logic [31:0] min_depth;
    logic [31:0] max_depth;
  } cell_result_t;

  typedef struct {
    gaic_item_t   stim;
    bit           typed;
    cell_result_t result;
  } sweep_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [271:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  gaic_reg_t    cfg_index = REG_TIME_STEP;
  logic [31:0]  cfg_data = '0;

  logic [31:0] dt_q = TIME_STEP_RST;
  logic [23:0] width_q = CELL_WIDTH_RST;
  logic        sma_q = 1'b0;
  logic [31:0] sweep_lo = '0;
  logic [31:0] sweep_hi = '0;

  cell_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int src_idle = 0;
  int sink_stall = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  green_ampt_infiltration_cell i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'(M32)) ? M32 : v[31:0];
  endfunction

  function automatic cell_result_t predict_cell(gaic_item_t c);
    logic [63:0] a, fi, two_f, sd, mag, r, t, sum, del, hd, q, rem, inc, w2, ach, area, add;
    logic [127:0] x, v;
    bit neg;
    cell_result_t o;
    o = '0;
    if (c.first_cell) begin
      sweep_lo = '0;
      sweep_hi = '0;
    end
    if (c.in_domain) begin
      a = (64'(c.conductivity) * 64'(dt_q)) >> 16;
      fi = 64'(c.cum_depth) << 16;
      two_f = fi << 1;
      sd = 64'(c.suction_head) * 64'(c.moisture_deficit);
      neg = a < two_f;
      mag = neg ? two_f - a : a - two_f;
      x = 128'(mag) * 128'(mag) + 128'(a) * 128'((fi + sd) << 3);
      r = '0;
      for (int b = 52; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (128'(t) * 128'(t) <= x) r = t;
      end
      sum = neg ? ((r >= mag) ? r - mag : 64'd0) : r + mag;
      del = sum >> 1;
      hd = 64'(c.ponded_depth) << 16;
      if (del > hd) del = hd;
      if (dt_q == 0) begin
        o.infil_rate = '0;
      end else begin
        q = del / dt_q;
        rem = del % dt_q;
        o.infil_rate = (q > 64'(M32)) ? M32 : sat32((q << 16) + ((rem << 16) / dt_q));
      end
      inc = 64'(sat32(del >> 16));
      o.new_depth = sat32(64'(c.cum_depth) + inc);
      w2 = 64'(width_q) * 64'(width_q);
      ach = c.is_channel ? 64'(c.channel_width) * 64'(c.channel_length) : 64'd0;
      area = (w2 > ach) ? w2 - ach : 64'd0;
      v = 128'(del) * 128'(area);
      add = ((v >> 104) != 0) ? 64'(M48) + 64'd1 : 64'(v >> 40);
      o.new_volume = (add > 64'(M48) || 64'(c.cum_volume) + add > 64'(M48)) ?
                     M48 : c.cum_volume + add[47:0];
      if (o.new_depth < sweep_lo) sweep_lo = o.new_depth;
      if (o.new_depth > sweep_hi) sweep_hi = o.new_depth;
      o.valid_cell = 1'b1;
      if (sma_q) begin
        o.step_infil_depth = inc[31:0];
        o.step_rain_depth = 32'((64'(c.rain_rate) * 64'(dt_q)) >> 32);
      end
    end
    o.min_depth = sweep_lo;
    o.max_depth = sweep_hi;
    return o;
  endfunction

  function automatic gaic_item_t make_cell(bit first, bit dom, bit chan, logic [31:0] h,
      logic [31:0] f, logic [47:0] vol, logic [31:0] k, logic [31:0] s, logic [15:0] d,
      logic [23:0] cw, logic [23:0] cl, logic [31:0] rain);
    gaic_item_t c;
    c = '{first, dom, chan, h, f, vol, k, s, d, cw, cl, rain};
    return c;
  endfunction

  function automatic logic [31:0] rand_mag32();
    case ($urandom_range(9))
      0: return '0;
      1: return M32;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic gaic_item_t rand_cell();
    logic [47:0] vol;
    vol = 48'({$urandom, $urandom} >> $urandom_range(16, 63));
    if ($urandom_range(19) == 0) vol = M48 - 48'($urandom_range(1000));
    return make_cell($urandom_range(19) == 0, $urandom_range(9) != 0, 1'($urandom_range(1)),
                     rand_mag32(), rand_mag32(), vol, rand_mag32(), rand_mag32(),
                     16'(rand_mag32()), 24'(rand_mag32()), 24'(rand_mag32()), rand_mag32());
  endfunction

  task automatic push_cell(gaic_item_t c, bit typed, cell_result_t given);
    cell_result_t p;
    if (src_idle > 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c.rain_rate, c.channel_length, c.channel_width, c.moisture_deficit,
                     c.suction_head, c.conductivity, c.cum_volume, c.cum_depth,
                     c.ponded_depth};
    s_axis_tuser <= {c.is_channel, c.in_domain, c.first_cell};
    do @(posedge clk); while (!s_axis_tready);
    p = predict_cell(c);
    pending_results.push_back(typed ? given : p);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(gaic_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIME_STEP:  dt_q = value;
      REG_CELL_WIDTH: width_q = value[23:0];
      default:        sma_q = value[0];
    endcase
  endtask

  always @(posedge clk) begin
    cell_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[111:64],
               m_axis_tdata[143:112], m_axis_tdata[175:144], m_axis_tdata[207:176],
               m_axis_tdata[239:208]};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat: %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch valid %b/%b rate %h/%h depth %h/%h vol %h/%h",
                       want.valid_cell, got.valid_cell, want.infil_rate, got.infil_rate,
                       want.new_depth, got.new_depth, want.new_volume, got.new_volume);
              $display("  step %h/%h rain %h/%h min %h/%h max %h/%h",
                       want.step_infil_depth, got.step_infil_depth, want.step_rain_depth,
                       got.step_rain_depth, want.min_depth, got.min_depth,
                       want.max_depth, got.max_depth);
            end
          end
        end
      end
    end
  end

  initial begin
    sweep_row_t rows[$];
    logic [31:0] phase_dt[8] = '{32'd65536, 32'd1, M32, 32'd262144, 32'd0,
                                 32'd235929600, 32'd0, 32'd3932160};
    logic [23:0] phase_w[8] = '{24'd25600, 24'd1, 24'hFFFFFF, 24'd12800, 24'd100,
                                24'd2560, 24'd0, 24'd7680};
    bit phase_sma[8] = '{1, 0, 1, 1, 1, 0, 1, 1};
    int phase_src[8] = '{0, 69, 0, 25, 0, 69, 0, 25};
    int phase_sink[8] = '{0, 0, 69, 25, 0, 0, 69, 25};
    cell_result_t z;
    z = '0;

    rows.push_back('{make_cell(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{make_cell(0, 0, 1, M32, M32, M48, M32, M32, 16'hFFFF, 24'hFFFFFF,
                               24'hFFFFFF, M32), 1, z});
    z.valid_cell = 1'b1;
    rows.push_back('{make_cell(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{make_cell(0, 1, 0, M32, 0, 0, M32, M32, 16'hFFFF, 0, 0, M32), 0, z});
    rows.push_back('{make_cell(0, 1, 1, M32, M32, M48, M32, M32, 16'hFFFF, 24'hFFFFFF,
                               24'hFFFFFF, M32), 0, z});
    rows.push_back('{make_cell(0, 1, 1, 32'd1 << 24, 32'd1 << 20, 0, 32'd1 << 28,
                               32'd1 << 23, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 32'd5), 0, z});
    rows.push_back('{make_cell(0, 1, 1, 32'd1 << 24, 32'd1 << 20, 0, 32'd1 << 28,
                               32'd1 << 23, 16'h8000, 0, 0, 32'd5), 0, z});
    rows.push_back('{make_cell(0, 1, 1, 32'd1 << 24, 32'd1 << 20, 0, 32'd1 << 28,
                               32'd1 << 23, 16'h8000, 24'd5120, 24'd25600, 32'd5), 0, z});
    rows.push_back('{make_cell(0, 1, 0, 0, 32'd1 << 24, 32'd77, 32'd1 << 30, M32, 16'h4000,
                               0, 0, 0), 0, z});
    rows.push_back('{make_cell(0, 1, 0, M32, M32, 0, 1, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{make_cell(0, 1, 0, M32, 0, 0, M32, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{make_cell(0, 1, 0, M32, 32'd100, M48, M32, M32, 16'hFFFF, 0, 0, 0),
                     0, z});
    rows.push_back('{make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{make_cell(1, 1, 0, 32'd1000, 32'd5000, 0, 32'd1 << 20, 32'd1 << 24,
                               16'h2000, 0, 0, 0), 0, z});
    rows.push_back('{make_cell(0, 1, 0, 32'd50, 32'd200, 0, 32'd1 << 20, 32'd1 << 24,
                               16'h2000, 0, 0, 0), 0, z});
    for (int i = 0; i < 5; i++) rows.push_back('{rand_cell(), 0, z});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) push_cell(rows[i].stim, rows[i].typed, rows[i].result);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_TIME_STEP, (ph == 6) ? $urandom_range(1, 32'h00FF_FFFF) : phase_dt[ph]);
      write_reg(REG_CELL_WIDTH, (ph == 6) ? $urandom_range(1, 24'h00FFFF) : phase_w[ph]);
      write_reg(REG_SMA_MODE, 32'(phase_sma[ph]));
      src_idle = phase_src[ph];
      sink_stall = phase_sink[ph];
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 235; n++) push_cell(rand_cell(), 0, z);
      drain_results();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
